@@ rtl/mrr_pkg.sv @@
`timescale 1ns / 1ps
// mrr_pkg: shared types, constants, the crc-16 byte update and the end-of-frame
// status check for the modbus rtu response receiver. no dependencies.

package mrr_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
   localparam logic [7:0] FC_EXC_FLAG     = 8'h80;
   localparam logic [7:0] ADDR_MIN        = 8'd1;
   localparam logic [7:0] ADDR_MAX        = 8'd247;

   localparam logic [9:0] LEN_EXCEPTION = 10'd5;
   localparam logic [9:0] LEN_WRITE     = 10'd8;
   localparam logic [9:0] LEN_OVERHEAD  = 10'd5;
   localparam logic [15:0] QTY_MAX      = 16'd123;

   localparam logic [7:0] CSR_EXPECTED_SLAVE    = 8'd0;
   localparam logic [7:0] CSR_EXPECTED_FUNCTION = 8'd1;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_EXCEPTION    = 3'd1,
      ST_BAD_CRC      = 3'd2,
      ST_SLAVE_MISM   = 3'd3,
      ST_FUNC_MISM    = 3'd4,
      ST_BAD_COUNT    = 3'd5,
      ST_BAD_QUANTITY = 3'd6
   } status_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] word_value;
      logic [6:0]  word_index;
      status_type  status;
      logic [7:0]  slave_id;
      logic [7:0]  exception_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [6:0]  word_count;
   } rsp_type;

   // reflected crc-16, one byte, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // end-of-frame status, checks in priority order
   function automatic rsp_type finish_frame(
      input logic [15:0] crc,
      input logic [7:0]  addr,
      input logic [7:0]  func,
      input logic [7:0]  count,
      input logic [15:0] start,
      input logic [15:0] qty,
      input logic [7:0]  exc,
      input logic [7:0]  exp_slave,
      input logic        exp_func
   );
      rsp_type     r;
      logic [7:0]  fexp;
      fexp = exp_func ? FC_WRITE_MULTI : FC_READ_HOLDING;
      r = '0;
      r.result_kind = KIND_STATUS;
      r.slave_id = exp_slave;
      if (crc != 16'h0000) begin
         r.status = ST_BAD_CRC;
      end else if (addr != exp_slave) begin
         r.status = ST_SLAVE_MISM;
         r.slave_id = addr;
      end else if (func == (fexp | FC_EXC_FLAG)) begin
         r.status = ST_EXCEPTION;
         r.exception_code = exc;
      end else if (func != fexp) begin
         r.status = ST_FUNC_MISM;
      end else if (!exp_func) begin
         if (count == 8'd0 || count[0]) begin
            r.status = ST_BAD_COUNT;
         end else begin
            r.status = ST_OK;
            r.word_count = count[7:1];
         end
      end else begin
         if (qty == 16'd0 || qty > QTY_MAX) begin
            r.status = ST_BAD_QUANTITY;
         end else begin
            r.status = ST_OK;
            r.start_address = start;
            r.quantity = qty;
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/mrr_frame_core.sv @@
`timescale 1ns / 1ps
// mrr_frame_core: frame delimiting state, running crc and result selection for
// one byte request per cycle while step is high. depends on mrr_pkg.

module mrr_frame_core #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            cmd,
   input  logic [7:0]      data_byte,
   input  logic [7:0]      expected_slave,
   input  logic            expected_function,
   output logic            result_valid,
   output mrr_pkg::rsp_type result
);
   import mrr_pkg::*;

   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [9:0] LEN_LIMIT_EXT = 10'(MAX_FRAME_BYTES);

   logic [LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [15:0]      running_crc_ff, running_crc_in;
   logic [7:0]       function_seen_ff, function_seen_in;
   logic [7:0]       payload_count_ff, payload_count_in;
   logic [7:0]       address_seen_ff, address_seen_in;
   logic [7:0]       pending_high_ff, pending_high_in;
   logic [15:0]      echoed_start_ff, echoed_start_in;
   logic [15:0]      echoed_quantity_ff, echoed_quantity_in;
   logic [7:0]       exception_seen_ff, exception_seen_in;

   logic [9:0]       pos_ext;
   logic [9:0]       len_next_ext;
   logic [9:0]       pair_pos;
   logic [9:0]       target;
   logic             drop;
   logic             fc_ok;

   always_comb begin
      frame_length_in    = frame_length_ff;
      running_crc_in     = running_crc_ff;
      function_seen_in   = function_seen_ff;
      payload_count_in   = payload_count_ff;
      address_seen_in    = address_seen_ff;
      pending_high_in    = pending_high_ff;
      echoed_start_in    = echoed_start_ff;
      echoed_quantity_in = echoed_quantity_ff;
      exception_seen_in  = exception_seen_ff;
      result_valid       = 1'b0;
      result             = '0;
      drop               = 1'b0;
      target             = '0;
      pos_ext            = 10'(frame_length_ff);
      len_next_ext       = pos_ext + 10'd1;
      pair_pos           = pos_ext - 10'd3;
      fc_ok = (data_byte == FC_READ_HOLDING) || (data_byte == FC_WRITE_MULTI) ||
              (data_byte == (FC_READ_HOLDING | FC_EXC_FLAG)) ||
              (data_byte == (FC_WRITE_MULTI | FC_EXC_FLAG));

      if (step) begin
         if (cmd) begin
            frame_length_in = '0;
            running_crc_in  = CRC_INIT;
         end else if (frame_length_ff == '0) begin
            // hunt for an address byte
            if (data_byte >= ADDR_MIN && data_byte <= ADDR_MAX) begin
               address_seen_in = data_byte;
               running_crc_in  = crc_byte(CRC_INIT, data_byte);
               frame_length_in = LEN_W'(1);
            end
         end else if (frame_length_ff >= LEN_LIMIT) begin
            frame_length_in = '0;
            running_crc_in  = CRC_INIT;
         end else begin
            running_crc_in  = crc_byte(running_crc_ff, data_byte);
            frame_length_in = frame_length_ff + LEN_W'(1);

            if (pos_ext == 10'd1) begin
               if (fc_ok) begin
                  function_seen_in = data_byte;
               end else begin
                  drop = 1'b1;
               end
            end else if (function_seen_ff[7]) begin
               if (pos_ext == 10'd2) begin
                  exception_seen_in = data_byte;
               end
            end else if (function_seen_ff == FC_WRITE_MULTI) begin
               case (pos_ext)
                  10'd2: echoed_start_in[15:8] = data_byte;
                  10'd3: echoed_start_in[7:0] = data_byte;
                  10'd4: echoed_quantity_in[15:8] = data_byte;
                  10'd5: echoed_quantity_in[7:0] = data_byte;
                  default: ;
               endcase
            end else begin
               if (pos_ext == 10'd2) begin
                  payload_count_in = data_byte;
               end else if (pair_pos < {2'b00, payload_count_ff}) begin
                  if (!pair_pos[0]) begin
                     pending_high_in = data_byte;
                  end else if ({2'b00, payload_count_ff} + LEN_OVERHEAD <= LEN_LIMIT_EXT) begin
                     // tentative word, only when the whole frame fits
                     result_valid       = 1'b1;
                     result.result_kind = KIND_WORD;
                     result.word_value  = {pending_high_ff, data_byte};
                     result.word_index  = pair_pos[7:1];
                  end
               end
            end

            if (drop) begin
               frame_length_in = '0;
               running_crc_in  = CRC_INIT;
            end else begin
               if (function_seen_in[7]) begin
                  target = LEN_EXCEPTION;
               end else if (function_seen_in == FC_WRITE_MULTI) begin
                  target = LEN_WRITE;
               end else if (len_next_ext < 10'd3) begin
                  target = '0;
               end else begin
                  target = {2'b00, payload_count_in} + LEN_OVERHEAD;
               end
               if (target != '0 && len_next_ext >= target) begin
                  if (len_next_ext == target) begin
                     result_valid = 1'b1;
                     result = finish_frame(running_crc_in, address_seen_in,
                                           function_seen_in, payload_count_in,
                                           echoed_start_in, echoed_quantity_in,
                                           exception_seen_in, expected_slave,
                                           expected_function);
                  end
                  frame_length_in = '0;
                  running_crc_in  = CRC_INIT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff    <= '0;
         running_crc_ff     <= CRC_INIT;
         function_seen_ff   <= '0;
         payload_count_ff   <= '0;
         address_seen_ff    <= '0;
         pending_high_ff    <= '0;
         echoed_start_ff    <= '0;
         echoed_quantity_ff <= '0;
         exception_seen_ff  <= '0;
      end else begin
         frame_length_ff    <= frame_length_in;
         running_crc_ff     <= running_crc_in;
         function_seen_ff   <= function_seen_in;
         payload_count_ff   <= payload_count_in;
         address_seen_ff    <= address_seen_in;
         pending_high_ff    <= pending_high_in;
         echoed_start_ff    <= echoed_start_in;
         echoed_quantity_ff <= echoed_quantity_in;
         exception_seen_ff  <= exception_seen_in;
      end
   end

endmodule

@@ rtl/mrr_out_reg.sv @@
`timescale 1ns / 1ps
// mrr_out_reg: result register between the frame core and the response stream.
// depends on mrr_pkg.

module mrr_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  mrr_pkg::rsp_type load_data,
   input  logic             out_ready,
   output logic             out_valid,
   output mrr_pkg::rsp_type out_data,
   output logic             free
);
   import mrr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/modbus_rtu_response_receiver.sv @@
`timescale 1ns / 1ps
// modbus rtu response receiver: one received byte per cycle, back to back, while
// the output register is free. a request is captured in the input register and
// parsed from it by the frame core; its result, if any, is registered onto rsp_.
// the byte-wide crc and length logic sets throughput at one byte per cycle.
// synchronous active-high reset closes any frame and sets expected slave 1, read.
// depends on mrr_pkg, mrr_frame_core and mrr_out_reg.

module modbus_rtu_response_receiver #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] word_value, [22:16] word_index, [25:23] status, [33:26] slave_id,
   // [41:34] exception_code, [57:42] start_address, [73:58] quantity,
   // [80:74] word_count, [87:81] zero
   output logic [87:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] result_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import mrr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff, in_cmd_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] exp_slave_ff, exp_slave_in;
   logic       exp_func_ff, exp_func_in;

   logic    advance;
   logic    out_free;
   logic    core_valid;
   rsp_type core_result;
   rsp_type out_result;

   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_cmd_in   = in_cmd_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_tuser;
         in_byte_in  = req_tdata;
      end
   end

   always_comb begin
      exp_slave_in = exp_slave_ff;
      exp_func_in  = exp_func_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECTED_SLAVE:    exp_slave_in = csr_data;
            CSR_EXPECTED_FUNCTION: exp_func_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         exp_slave_ff <= 8'd1;
         exp_func_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         exp_slave_ff <= exp_slave_in;
         exp_func_ff  <= exp_func_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff  <= in_cmd_in;
      in_byte_ff <= in_byte_in;
   end

   mrr_frame_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .cmd               (in_cmd_ff),
      .data_byte         (in_byte_ff),
      .expected_slave    (exp_slave_ff),
      .expected_function (exp_func_ff),
      .result_valid      (core_valid),
      .result            (core_result)
   );

   mrr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && core_valid),
      .load_data (core_result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_result),
      .free      (out_free)
   );

   assign rsp_tuser = out_result.result_kind;
   assign rsp_tdata = {7'd0, out_result.word_count, out_result.quantity,
                       out_result.start_address, out_result.exception_code,
                       out_result.slave_id, out_result.status,
                       out_result.word_index, out_result.word_value};

endmodule

@@ tb/sv/tb_modbus_pkg.sv @@
`timescale 1ns / 1ps
// tb_modbus_pkg: crc-16 byte update shared by the frame builder and the checker.
// depends on mrr_pkg for the polynomial.

package tb_modbus_pkg;

   // reflected crc-16 over one byte, lsb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) begin
         acc = acc[0] ? ((acc >> 1) ^ mrr_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

endpackage

@@ tb/sv/modbus_frame_checker.sv @@
`timescale 1ns / 1ps
// modbus_frame_checker: watches the request, response and csr channels of the
// response receiver, predicts each word and frame status and compares them.
// depends on mrr_pkg and tb_modbus_pkg.

module modbus_frame_checker #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          words_checked,
   output int          statuses_checked
);
   import mrr_pkg::*;
   import tb_modbus_pkg::*;

   // register copies
   logic [7:0]  cfg_slave;
   logic        cfg_write;

   // frame parser state
   int          frame_len;
   logic [15:0] crc_acc;
   logic [7:0]  func_code;
   logic [7:0]  byte_count;
   logic [7:0]  addr_byte;
   logic [7:0]  high_byte;
   logic [15:0] echo_start;
   logic [15:0] echo_qty;
   logic [7:0]  exc_byte;

   rsp_type     pending_results[$];

   function automatic void close_frame();
      frame_len = 0;
      crc_acc = CRC_INIT;
   endfunction

   function automatic rsp_type frame_status();
      rsp_type    s;
      logic [7:0] want_fc;
      want_fc = cfg_write ? FC_WRITE_MULTI : FC_READ_HOLDING;
      s = '0;
      s.result_kind = KIND_STATUS;
      s.slave_id = cfg_slave;
      s.status = ST_OK;
      if (crc_acc != 16'h0000) begin
         s.status = ST_BAD_CRC;
      end else if (addr_byte != cfg_slave) begin
         s.status = ST_SLAVE_MISM;
         s.slave_id = addr_byte;
      end else if (func_code == (want_fc | FC_EXC_FLAG)) begin
         s.status = ST_EXCEPTION;
         s.exception_code = exc_byte;
      end else if (func_code != want_fc) begin
         s.status = ST_FUNC_MISM;
      end else if (!cfg_write) begin
         if (byte_count == 8'd0 || byte_count[0]) begin
            s.status = ST_BAD_COUNT;
         end else begin
            s.word_count = byte_count[7:1];
         end
      end else if (echo_qty == 16'd0 || echo_qty > QTY_MAX) begin
         s.status = ST_BAD_QUANTITY;
      end else begin
         s.start_address = echo_start;
         s.quantity = echo_qty;
      end
      return s;
   endfunction

   // one line byte or discard; returns 1 when a word or status comes out
   function automatic bit parse_line_byte(input logic discard, input logic [7:0] b,
                                          output rsp_type r);
      int pos;
      int q;
      int goal;
      bit made;
      made = 1'b0;
      r = '0;
      if (discard) begin
         close_frame();
         return 1'b0;
      end
      if (frame_len == 0) begin
         // only a legal address opens a frame
         if (b >= ADDR_MIN && b <= ADDR_MAX) begin
            addr_byte = b;
            crc_acc = crc16_update(CRC_INIT, b);
            frame_len = 1;
         end
         return 1'b0;
      end
      if (frame_len >= MAX_FRAME_BYTES) begin
         close_frame();
         return 1'b0;
      end
      pos = frame_len;
      crc_acc = crc16_update(crc_acc, b);
      frame_len = frame_len + 1;
      if (pos == 1) begin
         if (!(b inside {FC_READ_HOLDING, FC_WRITE_MULTI, FC_READ_HOLDING | FC_EXC_FLAG,
                         FC_WRITE_MULTI | FC_EXC_FLAG})) begin
            close_frame();
            return 1'b0;
         end
         func_code = b;
      end else if (func_code[7]) begin
         if (pos == 2) exc_byte = b;
      end else if (func_code == FC_WRITE_MULTI) begin
         case (pos)
            2: echo_start[15:8] = b;
            3: echo_start[7:0] = b;
            4: echo_qty[15:8] = b;
            5: echo_qty[7:0] = b;
            default: ;
         endcase
      end else if (pos == 2) begin
         byte_count = b;
      end else begin
         q = pos - 3;
         if (q < int'(byte_count)) begin
            if (q % 2 == 0) begin
               high_byte = b;
            end else if (int'(byte_count) + 5 <= MAX_FRAME_BYTES) begin
               // tentative word, only when the frame can still complete
               r.result_kind = KIND_WORD;
               r.word_value = {high_byte, b};
               r.word_index = 7'(q / 2);
               made = 1'b1;
            end
         end
      end
      if (func_code[7]) goal = int'(LEN_EXCEPTION);
      else if (func_code == FC_WRITE_MULTI) goal = int'(LEN_WRITE);
      else if (frame_len < 3) goal = 0;
      else goal = int'(byte_count) + int'(LEN_OVERHEAD);
      if (goal != 0 && frame_len >= goal) begin
         if (frame_len == goal) begin
            r = frame_status();
            made = 1'b1;
         end
         close_frame();
      end
      return made;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got, inout bit bad);
      if (want !== got) begin
         bad = 1'b1;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      bit      made;
      bit      bad;
      if (reset) begin
         cfg_slave = ADDR_MIN;
         cfg_write = 1'b0;
         close_frame();
         func_code = '0;
         byte_count = '0;
         addr_byte = '0;
         high_byte = '0;
         echo_start = '0;
         echo_qty = '0;
         exc_byte = '0;
         pending_results.delete();
         fail_count = 0;
         words_checked = 0;
         statuses_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EXPECTED_SLAVE:    cfg_slave = csr_data;
               CSR_EXPECTED_FUNCTION: cfg_write = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            made = parse_line_byte(req_tuser, req_tdata, want);
            if (made) pending_results = {pending_results, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.result_kind = rsp_tuser;
            got.word_value = rsp_tdata[15:0];
            got.word_index = rsp_tdata[22:16];
            got.status = status_type'(rsp_tdata[25:23]);
            got.slave_id = rsp_tdata[33:26];
            got.exception_code = rsp_tdata[41:34];
            got.start_address = rsp_tdata[57:42];
            got.quantity = rsp_tdata[73:58];
            got.word_count = rsp_tdata[80:74];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               bad = 1'b0;
               check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind), bad);
               check_field("word_value", want.word_value, got.word_value, bad);
               check_field("word_index", 16'(want.word_index), 16'(got.word_index), bad);
               check_field("status", 16'(want.status), 16'(got.status), bad);
               check_field("slave_id", 16'(want.slave_id), 16'(got.slave_id), bad);
               check_field("exception_code", 16'(want.exception_code),
                           16'(got.exception_code), bad);
               check_field("start_address", want.start_address, got.start_address, bad);
               check_field("quantity", want.quantity, got.quantity, bad);
               check_field("word_count", 16'(want.word_count), 16'(got.word_count), bad);
               check_field("tdata padding", 16'h0000, 16'(rsp_tdata[87:81]), bad);
               if (bad) fail_count++;
               if (want.result_kind == KIND_STATUS) statuses_checked++;
               else words_checked++;
            end
         end
      end
      pending_count = pending_results.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: drives modbus rtu response frames, noise and discards into the response
// receiver across several register settings. depends on mrr_pkg, tb_modbus_pkg,
// modbus_frame_checker and the receiver rtl.

module tb_top;
   import mrr_pkg::*;
   import tb_modbus_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [7:0]  csr_data;

   int          fail_count;
   int          pending_count;
   int          words_checked;
   int          statuses_checked;

   bit          req_gaps_on;
   bit          rsp_stalls_on;
   bit          hold_off_req;
   logic [7:0]  cur_slave;
   logic [7:0]  frame_q[$];
   int          bytes_sent;
   int          frames_sent;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   modbus_rtu_response_receiver u_top (.*);

   modbus_frame_checker u_checker (.*);

   initial begin
      #10_000_000;
      $display("timeout, %0d results still outstanding", pending_count);
      $display("Verification failed");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int next_gap();
      int r;
      if (!req_gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(input logic cmd, input logic [7:0] b);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // let frames that give no result settle before touching the registers
   task automatic wait_idle();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic start_frame(input logic [7:0] addr, input logic [7:0] fc);
      frame_q.delete();
      frame_q = {frame_q, addr};
      frame_q = {frame_q, fc};
   endtask

   task automatic put_random(input int n);
      repeat (n) frame_q = {frame_q, 8'($urandom_range(0, 255))};
   endtask

   // append crc low byte first, optionally with one bit flipped in it
   task automatic seal(input bit corrupt);
      logic [15:0] crc;
      int          idx;
      crc = CRC_INIT;
      foreach (frame_q[i]) crc = crc16_update(crc, frame_q[i]);
      frame_q = {frame_q, crc[7:0]};
      frame_q = {frame_q, crc[15:8]};
      if (corrupt) begin
         idx = frame_q.size() - 1 - $urandom_range(0, 1);
         frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_req(1'b0, frame_q[i]);
      frames_sent++;
   endtask

   function automatic logic [7:0] pick_addr();
      if (cur_slave >= ADDR_MIN && cur_slave <= ADDR_MAX && $urandom_range(0, 99) < 80) begin
         return cur_slave;
      end
      return 8'($urandom_range(1, 247));
   endfunction

   task automatic random_frame();
      int          pick;
      int          k;
      int          cnt;
      logic [7:0]  addr;
      logic [7:0]  b;
      logic [15:0] qty;
      bit          bad_crc;
      pick = $urandom_range(0, 99);
      addr = pick_addr();
      bad_crc = ($urandom_range(0, 99) < 12);
      if (pick < 35) begin
         k = $urandom_range(0, 99);
         if (k < 80) cnt = 2 * $urandom_range(1, 8);
         else if (k < 88) cnt = 0;
         else if (k < 96) cnt = 2 * $urandom_range(0, 7) + 1;
         else cnt = $urandom_range(17, 40);
         start_frame(addr, FC_READ_HOLDING);
         frame_q = {frame_q, 8'(cnt)};
         put_random(cnt);
         seal(bad_crc);
         send_frame();
      end else if (pick < 55) begin
         k = $urandom_range(0, 99);
         if (k < 70) qty = 16'($urandom_range(1, 123));
         else if (k < 85) qty = 16'd0;
         else qty = 16'($urandom_range(124, 65535));
         start_frame(addr, FC_WRITE_MULTI);
         put_random(2);
         frame_q = {frame_q, qty[15:8]};
         frame_q = {frame_q, qty[7:0]};
         seal(bad_crc);
         send_frame();
      end else if (pick < 68) begin
         start_frame(addr, $urandom_range(0, 1) ? (FC_READ_HOLDING | FC_EXC_FLAG)
                                                : (FC_WRITE_MULTI | FC_EXC_FLAG));
         put_random(1);
         seal(bad_crc);
         send_frame();
      end else if (pick < 76) begin
         // unknown function code drops the frame
         do b = 8'($urandom_range(0, 255));
         while (b inside {FC_READ_HOLDING, FC_WRITE_MULTI, FC_READ_HOLDING | FC_EXC_FLAG,
                          FC_WRITE_MULTI | FC_EXC_FLAG});
         start_frame(addr, b);
         send_frame();
      end else if (pick < 86) begin
         // cut a frame short, then discard it
         cnt = 2 * $urandom_range(1, 8);
         start_frame(addr, FC_READ_HOLDING);
         frame_q = {frame_q, 8'(cnt)};
         put_random(cnt);
         seal(1'b0);
         k = $urandom_range(1, frame_q.size() - 1);
         for (int i = 0; i < k; i++) send_req(1'b0, frame_q[i]);
         send_req(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
         repeat ($urandom_range(1, 4)) send_req(1'b0, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) send_req(1'b1, 8'($urandom_range(0, 255)));
      end else begin
         send_req(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      logic [7:0] slave_val;
      logic       write_val;
      int         phase_start;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_off_req = 1'b0;
      cur_slave = ADDR_MIN;
      bytes_sent = 0;
      frames_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: slave 1, read holding registers
      send_req(1'b0, 8'h00);
      send_req(1'b0, 8'hF8);
      send_req(1'b0, 8'hFF);
      start_frame(ADDR_MIN, FC_READ_HOLDING);
      frame_q = {frame_q, 8'd4};
      frame_q = {frame_q, 8'hFF};
      frame_q = {frame_q, 8'hFF};
      frame_q = {frame_q, 8'h00};
      frame_q = {frame_q, 8'h00};
      seal(1'b0);
      send_frame();
      start_frame(ADDR_MIN, FC_READ_HOLDING | FC_EXC_FLAG);
      frame_q = {frame_q, 8'h02};
      seal(1'b0);
      send_frame();
      send_req(1'b0, ADDR_MAX);
      send_req(1'b1, 8'hFF);
      start_frame(ADDR_MIN, FC_WRITE_MULTI);
      frame_q = {frame_q, 8'h00};
      frame_q = {frame_q, 8'h00};
      frame_q = {frame_q, 8'h00};
      frame_q = {frame_q, 8'h01};
      seal(1'b0);
      send_frame();
      release_req();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin slave_val = ADDR_MIN; write_val = 1'b0; end
            1: begin slave_val = ADDR_MAX; write_val = 1'b1; end
            2: begin slave_val = 8'($urandom_range(2, 246)); write_val = 1'b0; end
            3: begin slave_val = 8'd0; write_val = 1'b1; end
            4: begin slave_val = 8'd255; write_val = 1'b0; end
            default: begin slave_val = 8'($urandom_range(1, 247)); write_val = 1'b1; end
         endcase
         wait_idle();
         write_csr(CSR_EXPECTED_SLAVE, slave_val);
         write_csr(CSR_EXPECTED_FUNCTION, {7'd0, write_val});
         cur_slave = slave_val;
         req_gaps_on = (phase != 1);
         rsp_stalls_on = (phase != 1);
         // back-to-back phase with the response side held off so the block backs up
         if (phase == 1) hold_off_req = 1'b1;
         if (phase == 2) begin
            // largest frame that fits, then one that overflows
            start_frame(cur_slave, FC_READ_HOLDING);
            frame_q = {frame_q, 8'd250};
            put_random(250);
            seal(1'b0);
            send_frame();
            start_frame(cur_slave, FC_READ_HOLDING);
            frame_q = {frame_q, 8'd252};
            put_random(252);
            seal(1'b0);
            send_frame();
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 30) random_frame();
         release_req();
      end

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("run covered %0d request bytes in %0d frames over six register settings",
               bytes_sent, frames_sent);
      $display("%0d register words and %0d frame status results compared",
               words_checked, statuses_checked);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ modbus_rtu_response_receiver.f @@
rtl/mrr_pkg.sv
rtl/mrr_frame_core.sv
rtl/mrr_out_reg.sv
rtl/modbus_rtu_response_receiver.sv
tb/sv/tb_modbus_pkg.sv
tb/sv/modbus_frame_checker.sv
tb/sv/tb_top.sv
